// ===== rtl/core/pcbd_pkg.sv =====
package pcbd_pkg;

  // Default sizes of the code table and of the longest code.
  localparam int unsigned MaxCodeLen  = 32;
  localparam int unsigned SymbolCount = 256;

  // Default depths of the command queue and of the result queue.
  localparam int unsigned CmdQueueDepth = 2;
  localparam int unsigned ResQueueDepth = 2;

  // Width of the stored code value and of the accumulator.
  localparam int unsigned CodeW = 32;

  // Operation codes of an input item.
  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  // One classified command, handed from the front end to the back end.
  typedef struct packed {
    op_e         kind;
    logic [7:0]  symbol;
    logic [31:0] code;
    logic [5:0]  length;
    logic [7:0]  data;
  } cmd_t;

  // One code table entry.
  typedef struct packed {
    logic [5:0]  length;
    logic [31:0] code;
  } entry_t;

  // One result item.
  typedef struct packed {
    logic [7:0] symbol;
    logic       overflow_error;
    logic       last_in_byte;
  } res_t;

endpackage

// ===== rtl/core/pcbd_if.sv =====
// Input channel: one table write or one data byte per transfer.
interface pcbd_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  entry_symbol;
  logic [31:0] entry_code;
  logic [5:0]  entry_length;
  logic [7:0]  data_byte;

  modport source (
    output valid, operation, entry_symbol, entry_code, entry_length, data_byte,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_symbol, entry_code, entry_length, data_byte,
    output ready
  );
endinterface

// Output channel: one decoded symbol or one overflow error per transfer.
interface pcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       overflow_error;
  logic       last_in_byte;

  modport source (
    output valid, symbol, overflow_error, last_in_byte,
    input  ready
  );
  modport sink (
    input  valid, symbol, overflow_error, last_in_byte,
    output ready
  );
endinterface

// ===== rtl/core/prefix_code_bitstream_decoder.sv =====
// Prefix-code (Huffman) decoder. An input transfer either writes one code table entry
// (symbol, right-aligned code value, length; length zero removes the entry) or hands
// in one data byte, whose bits are appended most significant first to an accumulator.
// When the accumulator equals a stored code of the same length, that symbol is sent
// out and the accumulator clears; the lowest symbol wins among equal entries. If the
// accumulator grows past MAX_CODE_LEN bits, a result with overflow_error set and
// symbol zero is sent instead. A byte yields zero to eight results, and the final
// one carries last_in_byte; leftover bits stay pending for the next byte. The table
// resets to all unused at once, so items are accepted right after reset. A front end
// classifies items into a small command queue; the back end handles one command at a
// time. A data byte is taken one bit at a time, with a scan of the table on the
// single read port of the table memory whenever the accumulator holds 1 to 32 bits:
// one entry per cycle, ending early at a match. Results pass through a small output
// queue.
module prefix_code_bitstream_decoder #(
  parameter int unsigned MAX_CODE_LEN    = pcbd_pkg::MaxCodeLen,
  parameter int unsigned SYMBOL_COUNT    = pcbd_pkg::SymbolCount,
  parameter int unsigned CMD_QUEUE_DEPTH = pcbd_pkg::CmdQueueDepth,
  parameter int unsigned RES_QUEUE_DEPTH = pcbd_pkg::ResQueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pcbd_in_if.sink      in_i,
  pcbd_out_if.source   out_o
);

  localparam int unsigned CmdW = $bits(pcbd_pkg::cmd_t);
  localparam int unsigned ResW = $bits(pcbd_pkg::res_t);

  logic            cmd_push_valid, cmd_push_ready;
  pcbd_pkg::cmd_t  cmd_push;
  logic            cmd_pop_valid, cmd_pop_ready;
  logic [CmdW-1:0] cmd_pop_raw;
  logic            res_push_valid, res_push_ready;
  pcbd_pkg::res_t  res_push;
  logic            res_pop_valid;
  logic [ResW-1:0] res_pop_raw;
  pcbd_pkg::res_t  res_pop;

  // Front end: accept and classify input transfers.
  pcbd_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_front (
    .in_i        (in_i),
    .cmd_valid_o (cmd_push_valid),
    .cmd_ready_i (cmd_push_ready),
    .cmd_o       (cmd_push)
  );

  // Command queue between the two ends.
  pcbd_fifo #(
    .WIDTH (CmdW),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_push_valid),
    .push_ready_o (cmd_push_ready),
    .push_data_i  (cmd_push),
    .pop_valid_o  (cmd_pop_valid),
    .pop_ready_i  (cmd_pop_ready),
    .pop_data_o   (cmd_pop_raw)
  );

  // Back end: table writes and bit-by-bit decoding.
  pcbd_back #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_pop_valid),
    .cmd_ready_o (cmd_pop_ready),
    .cmd_i       (pcbd_pkg::cmd_t'(cmd_pop_raw)),
    .res_valid_o (res_push_valid),
    .res_ready_i (res_push_ready),
    .res_o       (res_push)
  );

  // Result queue toward the output channel.
  pcbd_fifo #(
    .WIDTH (ResW),
    .DEPTH (RES_QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (res_push_valid),
    .push_ready_o (res_push_ready),
    .push_data_i  (res_push),
    .pop_valid_o  (res_pop_valid),
    .pop_ready_i  (out_o.ready),
    .pop_data_o   (res_pop_raw)
  );

  // Unpack the queued result onto the output channel.
  assign res_pop              = pcbd_pkg::res_t'(res_pop_raw);
  assign out_o.valid          = res_pop_valid;
  assign out_o.symbol         = res_pop.symbol;
  assign out_o.overflow_error = res_pop.overflow_error;
  assign out_o.last_in_byte   = res_pop.last_in_byte;

`ifndef SYNTHESIS
  // An overflow result always carries symbol zero.
  a_err_sym_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_valid && res_push.overflow_error |-> res_push.symbol == 8'd0)
    else $error("overflow result with nonzero symbol");

  // Taking a command from the queue never coincides with a result the next cycle.
  a_pop_then_no_res : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_valid && cmd_pop_ready |=> !res_push_valid)
    else $error("result transfer right after command pop");

  // The back end takes no command while it still has a result to hand over.
  a_no_pop_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_valid |-> !cmd_pop_ready)
    else $error("command pop while a result is pending");
`endif

endmodule

// ===== rtl/core/pcbd_fifo.sv =====
module pcbd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push_fire, pop_fire;

  // Handshake status follows the fill count.
  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = store_q[rd_ptr_q];
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;

  // Pointer and count updates, with wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_fire) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_fire) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_fire && !pop_fire) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_fire && pop_fire) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/pcbd_front.sv =====
module pcbd_front #(
  parameter int unsigned SYMBOL_COUNT = pcbd_pkg::SymbolCount
) (
  pcbd_in_if.sink         in_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output pcbd_pkg::cmd_t  cmd_o
);

  logic is_decode;
  logic sym_in_range;

  // Classify the item and drop table writes aimed past the last symbol.
  assign is_decode    = (in_i.operation == pcbd_pkg::OP_DECODE);
  assign sym_in_range = ({1'b0, in_i.entry_symbol} < 9'(SYMBOL_COUNT));

  assign cmd_valid_o = in_i.valid && (is_decode || sym_in_range);
  assign in_i.ready  = cmd_ready_i;

  // A dropped write is still taken from the channel, so ready only tracks the queue.
  always_comb begin
    cmd_o.kind   = is_decode ? pcbd_pkg::OP_DECODE : pcbd_pkg::OP_WRITE;
    cmd_o.symbol = in_i.entry_symbol;
    cmd_o.length = in_i.entry_length;
    cmd_o.code   = (in_i.entry_length == '0) ? '0 : in_i.entry_code;
    cmd_o.data   = in_i.data_byte;
  end

endmodule

// ===== rtl/core/pcbd_back.sv =====
module pcbd_back #(
  parameter int unsigned MAX_CODE_LEN = pcbd_pkg::MaxCodeLen,
  parameter int unsigned SYMBOL_COUNT = pcbd_pkg::SymbolCount
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  pcbd_pkg::cmd_t  cmd_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output pcbd_pkg::res_t  res_o
);

  localparam int unsigned AddrW = $clog2(SYMBOL_COUNT);
  localparam int unsigned CntW  = $clog2(MAX_CODE_LEN + 2);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(SYMBOL_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIT,
    S_SCAN,
    S_EMIT,
    S_FLUSH
  } state_e;

  state_e                       state_q, state_d;
  logic [7:0]                   byte_q, byte_d;
  logic [2:0]                   bit_idx_q, bit_idx_d;
  logic [pcbd_pkg::CodeW-1:0]   pend_bits_q, pend_bits_d;
  logic [CntW-1:0]              pend_cnt_q, pend_cnt_d;
  logic [pcbd_pkg::CodeW-1:0]   mask_q, mask_d;
  logic [AddrW-1:0]             scan_addr_q, scan_addr_d;
  logic                         issue_done_q, issue_done_d;
  logic                         cmp_vld_q, cmp_vld_d;
  logic [AddrW-1:0]             cmp_addr_q, cmp_addr_d;
  pcbd_pkg::res_t               new_res_q, new_res_d;
  pcbd_pkg::res_t               held_q, held_d;
  logic                         held_vld_q, held_vld_d;

  pcbd_pkg::entry_t             tbl_mem [SYMBOL_COUNT];
  pcbd_pkg::entry_t             rd_ent_q;
  logic                         rd_vld_q;
  logic [SYMBOL_COUNT-1:0]      ent_vld_q;

  logic [pcbd_pkg::CodeW-1:0]   next_bits;
  logic [CntW-1:0]              next_cnt;
  logic                         last_bit;
  logic                         hit;
  logic                         wr_en;
  logic                         rd_en;
  logic [AddrW-1:0]             wr_addr;
  pcbd_pkg::entry_t             wr_ent;

  // Table write port, used straight from the queue head while idle.
  assign wr_en          = (state_q == S_IDLE) && cmd_valid_i &&
                          (cmd_i.kind == pcbd_pkg::OP_WRITE);
  assign wr_addr        = cmd_i.symbol[AddrW-1:0];
  assign wr_ent.length  = cmd_i.length;
  assign wr_ent.code    = cmd_i.code;
  assign rd_en          = (state_q == S_SCAN) && !issue_done_q;
  assign cmd_ready_o    = (state_q == S_IDLE);

  // Next accumulator contents for the current bit of the byte.
  assign next_bits = {pend_bits_q[pcbd_pkg::CodeW-2:0], byte_q[bit_idx_q]};
  assign next_cnt  = pend_cnt_q + CntW'(1);
  assign last_bit  = (bit_idx_q == 3'd0);

  // Compare the entry read last cycle with the accumulator.
  assign hit = cmp_vld_q && rd_vld_q &&
               (7'(rd_ent_q.length) == 7'(pend_cnt_q)) &&
               (((rd_ent_q.code ^ pend_bits_q) & mask_q) == '0);

  // The held result goes out when the next one replaces it or when the byte ends.
  assign res_valid_o          = ((state_q == S_EMIT) || (state_q == S_FLUSH)) && held_vld_q;
  assign res_o.symbol         = held_q.symbol;
  assign res_o.overflow_error = held_q.overflow_error;
  assign res_o.last_in_byte   = (state_q == S_FLUSH);

  // Sequencer: one bit per step, each step scanning the table when a match is possible.
  always_comb begin
    state_d      = state_q;
    byte_d       = byte_q;
    bit_idx_d    = bit_idx_q;
    pend_bits_d  = pend_bits_q;
    pend_cnt_d   = pend_cnt_q;
    mask_d       = mask_q;
    scan_addr_d  = scan_addr_q;
    issue_done_d = issue_done_q;
    cmp_vld_d    = rd_en;
    cmp_addr_d   = scan_addr_q;
    new_res_d    = new_res_q;
    held_d       = held_q;
    held_vld_d   = held_vld_q;

    if (rd_en) begin
      if (scan_addr_q == LastAddr) begin
        issue_done_d = 1'b1;
      end else begin
        scan_addr_d = scan_addr_q + AddrW'(1);
      end
    end

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && (cmd_i.kind == pcbd_pkg::OP_DECODE)) begin
          byte_d    = cmd_i.data;
          bit_idx_d = 3'd7;
          state_d   = S_BIT;
        end
      end
      S_BIT: begin
        pend_bits_d = next_bits;
        pend_cnt_d  = next_cnt;
        if (next_cnt > CntW'(MAX_CODE_LEN)) begin
          // Accumulator ran past the longest code without a match.
          new_res_d.symbol         = '0;
          new_res_d.overflow_error = 1'b1;
          new_res_d.last_in_byte   = 1'b0;
          pend_bits_d = '0;
          pend_cnt_d  = '0;
          state_d     = S_EMIT;
        end else if (7'(next_cnt) <= 7'(pcbd_pkg::CodeW)) begin
          mask_d       = {pcbd_pkg::CodeW{1'b1}} >> (6'(pcbd_pkg::CodeW) - 6'(next_cnt));
          scan_addr_d  = '0;
          issue_done_d = 1'b0;
          state_d      = S_SCAN;
        end else if (last_bit) begin
          state_d = S_FLUSH;
        end else begin
          bit_idx_d = bit_idx_q - 3'd1;
          state_d   = S_BIT;
        end
      end
      S_SCAN: begin
        if (hit) begin
          // Ascending scan, so the first hit is the lowest symbol.
          new_res_d.symbol         = 8'(cmp_addr_q);
          new_res_d.overflow_error = 1'b0;
          new_res_d.last_in_byte   = 1'b0;
          pend_bits_d = '0;
          pend_cnt_d  = '0;
          state_d     = S_EMIT;
        end else if (cmp_vld_q && (cmp_addr_q == LastAddr)) begin
          if (last_bit) begin
            state_d = S_FLUSH;
          end else begin
            bit_idx_d = bit_idx_q - 3'd1;
            state_d   = S_BIT;
          end
        end
      end
      S_EMIT: begin
        if (!held_vld_q || res_ready_i) begin
          held_d     = new_res_q;
          held_vld_d = 1'b1;
          if (last_bit) begin
            state_d = S_FLUSH;
          end else begin
            bit_idx_d = bit_idx_q - 3'd1;
            state_d   = S_BIT;
          end
        end
      end
      S_FLUSH: begin
        if (!held_vld_q || res_ready_i) begin
          held_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      byte_q       <= '0;
      bit_idx_q    <= '0;
      pend_bits_q  <= '0;
      pend_cnt_q   <= '0;
      mask_q       <= '0;
      scan_addr_q  <= '0;
      issue_done_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      cmp_addr_q   <= '0;
      new_res_q    <= '0;
      held_q       <= '0;
      held_vld_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      byte_q       <= byte_d;
      bit_idx_q    <= bit_idx_d;
      pend_bits_q  <= pend_bits_d;
      pend_cnt_q   <= pend_cnt_d;
      mask_q       <= mask_d;
      scan_addr_q  <= scan_addr_d;
      issue_done_q <= issue_done_d;
      cmp_vld_q    <= cmp_vld_d;
      cmp_addr_q   <= cmp_addr_d;
      new_res_q    <= new_res_d;
      held_q       <= held_d;
      held_vld_q   <= held_vld_d;
    end
  end

  // Entry valid bits: an entry never written reads as unused.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= ent_vld_q[scan_addr_q];
      end
    end
  end

  // Code table memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_ent;
    end
    if (rd_en) begin
      rd_ent_q <= tbl_mem[scan_addr_q];
    end
  end

endmodule
